// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/ace_pkg.sv
`default_nettype none

package ace_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam logic [7:0] AGE_LIMIT_DEF = 8'd120;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_LEARN_IP  = 2'd1,
    ACT_LEARN_ARP = 2'd2,
    ACT_RESOLVE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_TICK_DONE = 3'd0,
    STS_REFRESHED = 3'd1,
    STS_CREATED   = 3'd2,
    STS_REPLACED  = 3'd3,
    STS_HIT       = 3'd4,
    STS_MISS      = 3'd5,
    STS_BCAST     = 3'd6,
    STS_IGNORED   = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP    = 3'd0,
    CFG_NET_MASK  = 3'd1,
    CFG_GATEWAY   = 3'd2,
    CFG_BCAST_IP  = 3'd3,
    CFG_MAX_AGE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CS_IDLE   = 2'd0,
    CS_SCAN   = 2'd1,
    CS_FINISH = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic [31:0] arp_target_ip;
    logic [1:0]  arp_opcode;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [47:0] resolved_mac;
    logic [31:0] next_hop_ip;
    logic        send_reply;
    logic [3:0]  expired_count;
  } out_word_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/ace_ctrl.sv
`default_nettype none

module ace_ctrl
  import ace_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire dp_status_t                   sts,
  output ctrl_cmd_t                         cmd,
  output logic [$clog2(ENTRIES)-1:0]        rd_addr
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  ctrl_state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign rd_addr = cnt[IDX_W-1:0];

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          cnt_next   = '0;
          state_next = CS_SCAN;
        end
      end
      CS_SCAN: begin
        // read entry cnt; its compare happens in the cycle after
        if (cnt == CNT_W'(ENTRIES)) begin
          state_next = CS_FINISH;
        end else begin
          cmd.issue = 1'b1;
          cnt_next  = cnt + 1'b1;
        end
      end
      CS_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/ace_datapath.sv
`default_nettype none

module ace_datapath
  import ace_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [31:0]                  cfg_data,
  input  wire in_word_t                     in_word,
  input  wire ctrl_cmd_t                    cmd,
  input  wire logic [$clog2(ENTRIES)-1:0]   rd_addr,
  output dp_status_t                        sts,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output out_word_t                         out_word
);

  localparam int IDX_W = $clog2(ENTRIES);

  // configuration
  logic [31:0] own_ip, net_mask, gateway_ip, broadcast_ip;
  logic [7:0]  max_age;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip       <= '0;
      net_mask     <= '0;
      gateway_ip   <= '0;
      broadcast_ip <= '1;
      max_age      <= AGE_LIMIT_DEF;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_OWN_IP:   own_ip       <= cfg_data;
        CFG_NET_MASK: net_mask     <= cfg_data;
        CFG_GATEWAY:  gateway_ip   <= cfg_data;
        CFG_BCAST_IP: broadcast_ip <= cfg_data;
        CFG_MAX_AGE:  max_age      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // latched item and flags derived at accept
  action_t     act;
  logic [31:0] ip_r, key_r;
  logic [47:0] mac_r;
  logic [1:0]  opcode_r;
  logic        on_sub_r, bcast_r, arp_ok_r;
  logic        in_on_sub;

  assign in_on_sub = (in_word.ip_address & net_mask) == (own_ip & net_mask);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act      <= action_t'(in_word.action);
      ip_r     <= in_word.ip_address;
      mac_r    <= in_word.mac_address;
      opcode_r <= in_word.arp_opcode;
      on_sub_r <= in_on_sub;
      bcast_r  <= in_word.ip_address == broadcast_ip;
      arp_ok_r <= (in_word.arp_target_ip == own_ip) &&
                  (in_word.arp_opcode == OP_REQUEST || in_word.arp_opcode == OP_REPLY);
      // resolve looks up the next hop; learns look up the sender
      if (action_t'(in_word.action) == ACT_RESOLVE && !in_on_sub) begin
        key_r <= gateway_ip;
      end else begin
        key_r <= in_word.ip_address;
      end
    end
  end

  // entry table
  entry_t             mem [ENTRIES];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_slot;
  logic               rd_live;
  logic [ENTRIES-1:0] valid;
  logic [7:0]         tick_clock;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
      rd_slot <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else begin
      rd_live <= cmd.issue;
    end
  end

  // scan accumulators
  logic             match_found, empty_found;
  logic [IDX_W-1:0] match_idx, empty_idx, best_idx;
  logic [47:0]      match_mac;
  logic [7:0]       best_age;
  logic [3:0]       expired;
  logic             cur_valid, cur_hit, cur_expire;
  logic [7:0]       cur_age;

  assign cur_valid  = valid[rd_slot];
  assign cur_hit    = cur_valid && (rd_data.ip == key_r);
  assign cur_age    = tick_clock - rd_data.stamp;
  assign cur_expire = rd_live && (act == ACT_TICK) && cur_valid && (cur_age >= max_age);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      match_found <= 1'b0;
      empty_found <= 1'b0;
      match_idx   <= '0;
      empty_idx   <= '0;
      best_idx    <= '0;
      best_age    <= '0;
      expired     <= '0;
    end else if (rd_live) begin
      if (cur_hit && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= rd_slot;
        match_mac   <= rd_data.mac;
      end
      if (!cur_valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_idx   <= rd_slot;
      end
      // strict compare keeps the first of equal ages
      if (cur_age > best_age) begin
        best_age <= cur_age;
        best_idx <= rd_slot;
      end
      if (cur_expire && expired != 4'd15) begin
        expired <= expired + 4'd1;
      end
    end
  end

  // commit decision
  out_word_t        out_next;
  logic             do_write;
  logic [IDX_W-1:0] pick;

  always_comb begin
    out_next = '0;
    do_write = 1'b0;
    pick     = best_idx;
    out_next.status = STS_IGNORED;
    if (match_found) begin
      pick = match_idx;
    end else if (empty_found) begin
      pick = empty_idx;
    end
    case (act)
      ACT_TICK: begin
        out_next.status        = STS_TICK_DONE;
        out_next.expired_count = expired;
      end
      ACT_LEARN_IP, ACT_LEARN_ARP: begin
        if ((act == ACT_LEARN_IP) ? on_sub_r : arp_ok_r) begin
          do_write             = 1'b1;
          out_next.slot        = 3'(pick);
          out_next.next_hop_ip = ip_r;
          out_next.send_reply  = (act == ACT_LEARN_ARP) && (opcode_r == OP_REQUEST);
          if (match_found) begin
            out_next.status = STS_REFRESHED;
          end else if (empty_found) begin
            out_next.status = STS_CREATED;
          end else begin
            out_next.status = STS_REPLACED;
          end
        end
      end
      ACT_RESOLVE: begin
        if (bcast_r) begin
          out_next.status       = STS_BCAST;
          out_next.resolved_mac = '1;
          out_next.next_hop_ip  = ip_r;
        end else begin
          out_next.next_hop_ip = key_r;
          if (match_found) begin
            out_next.status       = STS_HIT;
            out_next.slot         = 3'(match_idx);
            out_next.resolved_mac = match_mac;
          end else begin
            out_next.status = STS_MISS;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      mem[pick] <= '{ip: ip_r, mac: mac_r, stamp: tick_clock};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      tick_clock <= '0;
    end else begin
      if (cur_expire) begin
        valid[rd_slot] <= 1'b0;
      end
      if (cmd.commit && do_write) begin
        valid[pick] <= 1'b1;
      end
      if (cmd.commit && act == ACT_TICK) begin
        tick_clock <= tick_clock + 8'd1;
      end
    end
  end

  // output word register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_word <= out_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/arp_cache_engine.sv
`default_nettype none

// IPv4-to-MAC cache of ENTRIES entries with tick-based aging. Each request
// word (tick, learn from IP, learn from ARP, resolve) scans the table one
// entry per cycle through the single read port of the entry memory, then
// commits: the result word is written into the output register once that
// register is free. The engine works on one word at a time and takes the
// next word only after that commit, back in its idle state. The
// result sits in an output register, so a new request word is taken while the
// previous result still waits for out_ready; its commit then waits until the
// register frees. Configuration writes are taken at any time (cfg_ready is
// always high) and must only be issued while the engine is idle. Valid bits
// clear on reset; no clearing pass is needed.

module arp_cache_engine
  import ace_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_word_t                 out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  ctrl_cmd_t                    cmd;
  dp_status_t                   sts;
  logic [$clog2(ENTRIES)-1:0]   rd_addr;

  assign cfg_ready = 1'b1;

  ace_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  ace_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// File: rtl/core/ace_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ace_checker
  import ace_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  logic tick_out, bcast_out, reply_out, expired_out;
  logic tick_fields_zero, bcast_mac_ones, wrote_entry, is_tick;

  assign tick_out    = out_valid && out_word.status == STS_TICK_DONE;
  assign bcast_out   = out_valid && out_word.status == STS_BCAST;
  assign reply_out   = out_valid && out_word.send_reply;
  assign expired_out = out_valid && out_word.expired_count != 4'd0;

  assign tick_fields_zero = out_word.slot == 3'd0 && out_word.resolved_mac == 48'd0 &&
                            out_word.next_hop_ip == 32'd0 && !out_word.send_reply;
  assign bcast_mac_ones   = out_word.resolved_mac == 48'hFFFF_FFFF_FFFF;
  assign wrote_entry      = out_word.status == STS_REFRESHED ||
                            out_word.status == STS_CREATED ||
                            out_word.status == STS_REPLACED;
  assign is_tick          = out_word.status == STS_TICK_DONE;

  // engine takes one word at a time, so it is busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  `ASSERT_IMPLY(a_tick_clean, clk, rst, tick_out, tick_fields_zero)

  `ASSERT_IMPLY(a_bcast_mac, clk, rst, bcast_out, bcast_mac_ones)

  `ASSERT_IMPLY(a_reply_on_write, clk, rst, reply_out, wrote_entry)

  `ASSERT_IMPLY(a_expired_tick_only, clk, rst, expired_out, is_tick)

endmodule

bind arp_cache_engine ace_checker u_ace_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb
  import ace_pkg::*;
();

  localparam int N = ENTRIES_DEF;
  localparam int LIMIT = 400000;
  localparam int PHASE_WORDS = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL = 12;
  localparam logic [1:0] ARP_OP_OTHER = 2'd0;
  localparam logic [1:0] ARP_OP_SPARE = 2'd3;
  localparam logic [47:0] MAC_ONES = '1;

  typedef struct packed {
    logic [31:0] own;
    logic [31:0] mask;
    logic [31:0] gw;
    logic [31:0] bcast;
    logic [7:0]  age;
  } cfg_set_t;

  typedef struct {
    bit        is_cfg;
    cfg_set_t  setting;
    in_word_t  word;
    bit        pinned;
    out_word_t want;
  } plan_row_t;

  logic clk, rst;
  logic in_valid, in_ready;
  in_word_t in_word;
  logic out_valid, out_ready;
  out_word_t out_word;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // rides along with in_word: a hand-typed result that replaces the predicted one
  logic pin_on;
  out_word_t pin_word;

  // cache image kept by the predictor
  logic [31:0] tbl_ip [N];
  logic [47:0] tbl_mac [N];
  logic [7:0] tbl_stamp [N];
  bit tbl_live [N];
  logic [7:0] ticks_now;
  cfg_set_t model_cfg;

  cfg_set_t set_cur;
  logic [31:0] addr_pool [POOL];
  out_word_t pending_q [$];
  plan_row_t plan [$];

  int n_errors, n_checked, n_settings, n_expired, cycles;
  int status_tally [8];
  int send_pct, recv_pct;
  bit hold_req;

  arp_cache_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("tb: word %0d %s: got %h want %h", n_checked, what, got, want);
  endtask

  // refresh a matching entry, else take the first empty one, else the oldest
  function automatic status_t cache_store(input logic [31:0] ip, input logic [47:0] mac,
                                          output logic [2:0] where);
    int pick;
    logic [7:0] oldest, a;
    bit found;
    status_t st;
    pick = 0;
    oldest = 8'd0;
    found = 0;
    st = STS_CREATED;
    for (int i = 0; i < N; i++)
      if (tbl_live[i] && tbl_ip[i] == ip) begin
        tbl_mac[i] = mac;
        tbl_stamp[i] = ticks_now;
        where = 3'(i);
        return STS_REFRESHED;
      end
    for (int i = N - 1; i >= 0; i--)
      if (!tbl_live[i]) begin
        pick = i;
        found = 1;
      end
    if (!found) begin
      st = STS_REPLACED;
      for (int i = 0; i < N; i++) begin
        a = ticks_now - tbl_stamp[i];
        if (a > oldest) begin
          oldest = a;
          pick = i;
        end
      end
    end
    tbl_ip[pick] = ip;
    tbl_mac[pick] = mac;
    tbl_stamp[pick] = ticks_now;
    tbl_live[pick] = 1;
    where = 3'(pick);
    return st;
  endfunction

  function automatic out_word_t cache_predict(input in_word_t w);
    out_word_t r;
    logic [31:0] hop;
    logic [7:0] a;
    logic [2:0] where;
    r = '0;
    r.status = STS_IGNORED;
    case (w.action)
      ACT_TICK: begin
        for (int i = 0; i < N; i++) begin
          a = ticks_now - tbl_stamp[i];
          if (tbl_live[i] && a >= model_cfg.age) begin
            tbl_live[i] = 0;
            tbl_ip[i] = '0;
            tbl_mac[i] = '0;
            tbl_stamp[i] = '0;
            if (r.expired_count != 4'd15) r.expired_count = r.expired_count + 4'd1;
          end
        end
        ticks_now = ticks_now + 8'd1;
        r.status = STS_TICK_DONE;
      end
      ACT_LEARN_IP: begin
        if ((w.ip_address & model_cfg.mask) == (model_cfg.own & model_cfg.mask)) begin
          r.status = cache_store(w.ip_address, w.mac_address, where);
          r.slot = where;
          r.next_hop_ip = w.ip_address;
        end
      end
      ACT_LEARN_ARP: begin
        if (w.arp_target_ip == model_cfg.own &&
            (w.arp_opcode == OP_REQUEST || w.arp_opcode == OP_REPLY)) begin
          r.status = cache_store(w.ip_address, w.mac_address, where);
          r.slot = where;
          r.next_hop_ip = w.ip_address;
          r.send_reply = (w.arp_opcode == OP_REQUEST);
        end
      end
      default: begin
        if (w.ip_address == model_cfg.bcast) begin
          r.status = STS_BCAST;
          r.resolved_mac = MAC_ONES;
          r.next_hop_ip = w.ip_address;
        end else begin
          hop = ((w.ip_address & model_cfg.mask) == (model_cfg.own & model_cfg.mask)) ?
                w.ip_address : model_cfg.gw;
          r.status = STS_MISS;
          r.next_hop_ip = hop;
          // walk down so the lowest matching entry wins
          for (int i = N - 1; i >= 0; i--)
            if (tbl_live[i] && tbl_ip[i] == hop) begin
              r.status = STS_HIT;
              r.slot = 3'(i);
              r.resolved_mac = tbl_mac[i];
            end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want, guess;
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          CFG_OWN_IP:   model_cfg.own = cfg_data;
          CFG_NET_MASK: model_cfg.mask = cfg_data;
          CFG_GATEWAY:  model_cfg.gw = cfg_data;
          CFG_BCAST_IP: model_cfg.bcast = cfg_data;
          CFG_MAX_AGE:  model_cfg.age = cfg_data[7:0];
          default: ;
        endcase
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected word, status", 64'(out_word.status), 64'd0);
        end else begin
          want = pending_q.pop_front();
          if (out_word.status !== want.status)
            report_mismatch("status", 64'(out_word.status), 64'(want.status));
          if (out_word.slot !== want.slot)
            report_mismatch("slot", 64'(out_word.slot), 64'(want.slot));
          if (out_word.resolved_mac !== want.resolved_mac)
            report_mismatch("resolved_mac", 64'(out_word.resolved_mac),
                            64'(want.resolved_mac));
          if (out_word.next_hop_ip !== want.next_hop_ip)
            report_mismatch("next_hop_ip", 64'(out_word.next_hop_ip),
                            64'(want.next_hop_ip));
          if (out_word.send_reply !== want.send_reply)
            report_mismatch("send_reply", 64'(out_word.send_reply), 64'(want.send_reply));
          if (out_word.expired_count !== want.expired_count)
            report_mismatch("expired_count", 64'(out_word.expired_count),
                            64'(want.expired_count));
        end
        n_checked++;
      end
      if (in_valid && in_ready) begin
        guess = cache_predict(in_word);
        want = pin_on ? pin_word : guess;
        pending_q.push_back(want);
        status_tally[want.status]++;
        n_expired += want.expired_count;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  task automatic offer_word(input in_word_t w, input bit pin, input out_word_t want);
    in_valid <= 1'b1;
    in_word <= w;
    pin_on <= pin;
    pin_word <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < send_pct) n++;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input cfg_set_t s);
    drain_results();
    repeat (16) @(posedge clk);
    write_reg(CFG_OWN_IP, s.own);
    write_reg(CFG_NET_MASK, s.mask);
    write_reg(CFG_GATEWAY, s.gw);
    write_reg(CFG_BCAST_IP, s.bcast);
    write_reg(CFG_MAX_AGE, {24'd0, s.age});
    cfg_valid <= 1'b0;
    set_cur = s;
    n_settings++;
  endtask

  function automatic in_word_t mk_in(input action_t a, input logic [31:0] ip,
                                     input logic [47:0] mac, input logic [31:0] tgt,
                                     input logic [1:0] op);
    in_word_t w;
    w.action = a;
    w.ip_address = ip;
    w.mac_address = mac;
    w.arp_target_ip = tgt;
    w.arp_opcode = op;
    return w;
  endfunction

  function automatic out_word_t mk_out(input status_t s, input logic [2:0] sl,
                                       input logic [47:0] mac, input logic [31:0] hop,
                                       input logic reply, input logic [3:0] gone);
    out_word_t r;
    r.status = s;
    r.slot = sl;
    r.resolved_mac = mac;
    r.next_hop_ip = hop;
    r.send_reply = reply;
    r.expired_count = gone;
    return r;
  endfunction

  task automatic add_item(input in_word_t w, input bit pin, input out_word_t want);
    plan_row_t row;
    row.is_cfg = 0;
    row.setting = '0;
    row.word = w;
    row.pinned = pin;
    row.want = want;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input cfg_set_t s);
    plan_row_t row;
    row.is_cfg = 1;
    row.setting = s;
    row.word = '0;
    row.pinned = 0;
    row.want = '0;
    plan.push_back(row);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int r;
    w.ip_address = $urandom;
    w.mac_address = {16'($urandom), 32'($urandom)};
    w.arp_target_ip = $urandom;
    w.arp_opcode = 2'($urandom);
    r = $urandom_range(99);
    if (r < 18) begin
      w.action = ACT_TICK;
    end else if (r < 43) begin
      w.action = ACT_LEARN_IP;
      if ($urandom_range(99) < 85) w.ip_address = addr_pool[$urandom_range(POOL - 1)];
    end else if (r < 68) begin
      w.action = ACT_LEARN_ARP;
      if ($urandom_range(99) < 80) w.ip_address = addr_pool[$urandom_range(POOL - 1)];
      if ($urandom_range(99) < 80) w.arp_target_ip = set_cur.own;
      r = $urandom_range(99);
      w.arp_opcode = (r < 40) ? OP_REQUEST : (r < 80) ? OP_REPLY :
                     (r < 90) ? ARP_OP_OTHER : ARP_OP_SPARE;
    end else begin
      w.action = ACT_RESOLVE;
      r = $urandom_range(99);
      if (r < 8) w.ip_address = set_cur.bcast;
      else if (r >= 20) w.ip_address = addr_pool[$urandom_range(POOL - 1)];
    end
    return w;
  endfunction

  initial begin
    cfg_set_t s;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OWN_IP;
    cfg_data = '0;
    pin_on = 1'b0;
    pin_word = '0;
    hold_req = 0;
    send_pct = 0;
    recv_pct = 0;
    n_errors = 0;
    n_checked = 0;
    n_settings = 0;
    n_expired = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    for (int i = 0; i < N; i++) begin
      tbl_ip[i] = '0;
      tbl_mac[i] = '0;
      tbl_stamp[i] = '0;
      tbl_live[i] = 0;
    end
    ticks_now = '0;
    model_cfg = {32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, AGE_LIMIT_DEF};
    set_cur = model_cfg;

    // reset values: no mask, so every address is local
    add_item(mk_in(ACT_RESOLVE, 32'hFFFF_FFFF, MAC_ONES, 32'hFFFF_FFFF, ARP_OP_SPARE), 1,
             mk_out(STS_BCAST, 3'd0, MAC_ONES, 32'hFFFF_FFFF, 1'b0, 4'd0));
    add_item(mk_in(ACT_RESOLVE, 32'h0A00_0001, '0, '0, ARP_OP_OTHER), 1,
             mk_out(STS_MISS, 3'd0, '0, 32'h0A00_0001, 1'b0, 4'd0));
    add_item(mk_in(ACT_TICK, 32'hFFFF_FFFF, MAC_ONES, 32'hFFFF_FFFF, ARP_OP_SPARE), 1,
             mk_out(STS_TICK_DONE, 3'd0, '0, '0, 1'b0, 4'd0));
    add_item(mk_in(ACT_LEARN_IP, 32'h0A00_0001, MAC_ONES, '0, OP_REQUEST), 1,
             mk_out(STS_CREATED, 3'd0, '0, 32'h0A00_0001, 1'b0, 4'd0));
    add_item(mk_in(ACT_LEARN_IP, 32'h0A00_0001, '0, '0, ARP_OP_OTHER), 1,
             mk_out(STS_REFRESHED, 3'd0, '0, 32'h0A00_0001, 1'b0, 4'd0));
    add_item(mk_in(ACT_RESOLVE, 32'h0A00_0001, MAC_ONES, '0, ARP_OP_OTHER), 1,
             mk_out(STS_HIT, 3'd0, '0, 32'h0A00_0001, 1'b0, 4'd0));
    add_item(mk_in(ACT_LEARN_ARP, 32'h0A00_0002, 48'h1234_5678_9ABC, '0, OP_REQUEST), 1,
             mk_out(STS_CREATED, 3'd1, '0, 32'h0A00_0002, 1'b1, 4'd0));
    add_item(mk_in(ACT_LEARN_ARP, 32'hFFFF_FFFF, 48'hA5A5_5A5A_C3C3, '0, OP_REPLY), 1,
             mk_out(STS_CREATED, 3'd2, '0, 32'hFFFF_FFFF, 1'b0, 4'd0));
    add_item(mk_in(ACT_LEARN_ARP, 32'h0A00_0004, MAC_ONES, '0, ARP_OP_OTHER), 1,
             mk_out(STS_IGNORED, 3'd0, '0, '0, 1'b0, 4'd0));
    add_item(mk_in(ACT_LEARN_ARP, 32'h0A00_0004, MAC_ONES, '0, ARP_OP_SPARE), 1,
             mk_out(STS_IGNORED, 3'd0, '0, '0, 1'b0, 4'd0));
    // target is not us
    add_item(mk_in(ACT_LEARN_ARP, 32'h0A00_0004, MAC_ONES, 32'hFFFF_FFFF, OP_REQUEST), 1,
             mk_out(STS_IGNORED, 3'd0, '0, '0, 1'b0, 4'd0));
    add_item(mk_in(ACT_LEARN_IP, 32'h0000_0000, 48'h0000_0000_0001, '0, OP_REPLY), 0, '0);
    add_item(mk_in(ACT_RESOLVE, 32'h0000_0000, '0, '0, OP_REPLY), 0, '0);

    add_cfg({32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'hC0A8_01FF, 8'd1});
    add_item(mk_in(ACT_LEARN_IP, 32'h0808_0808, MAC_ONES, '0, OP_REQUEST), 1,
             mk_out(STS_IGNORED, 3'd0, '0, '0, 1'b0, 4'd0));
    // ARP learning does not care about the subnet
    add_item(mk_in(ACT_LEARN_ARP, 32'h0808_0808, 48'h0202_0304_0506, 32'hC0A8_010A,
                   OP_REPLY), 0, '0);
    add_item(mk_in(ACT_LEARN_IP, 32'hC0A8_0102, 48'h0202_0000_0102, '0, ARP_OP_OTHER), 0, '0);
    add_item(mk_in(ACT_LEARN_IP, 32'hC0A8_0103, 48'h0202_0000_0103, '0, ARP_OP_OTHER), 0, '0);
    add_item(mk_in(ACT_LEARN_IP, 32'hC0A8_0101, 48'h0202_0000_0101, '0, ARP_OP_OTHER), 0, '0);
    // table full, all ages zero: entry zero goes
    add_item(mk_in(ACT_LEARN_IP, 32'hC0A8_0104, 48'h0202_0000_0104, '0, ARP_OP_OTHER), 1,
             mk_out(STS_REPLACED, 3'd0, '0, 32'hC0A8_0104, 1'b0, 4'd0));
    add_item(mk_in(ACT_RESOLVE, 32'h0808_0808, '0, '0, ARP_OP_OTHER), 0, '0);
    add_item(mk_in(ACT_RESOLVE, 32'hC0A8_01FF, '0, '0, ARP_OP_OTHER), 1,
             mk_out(STS_BCAST, 3'd0, MAC_ONES, 32'hC0A8_01FF, 1'b0, 4'd0));
    add_item(mk_in(ACT_TICK, '0, '0, '0, ARP_OP_OTHER), 1,
             mk_out(STS_TICK_DONE, 3'd0, '0, '0, 1'b0, 4'd0));
    add_item(mk_in(ACT_TICK, '0, '0, '0, ARP_OP_OTHER), 1,
             mk_out(STS_TICK_DONE, 3'd0, '0, '0, 1'b0, 4'd8));
    add_item(mk_in(ACT_RESOLVE, 32'h0A0A_0A0A, '0, '0, ARP_OP_OTHER), 1,
             mk_out(STS_MISS, 3'd0, '0, 32'hC0A8_0101, 1'b0, 4'd0));
    // zero age limit: everything valid expires on the next tick
    add_cfg({32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'hC0A8_01FF, 8'd0});
    add_item(mk_in(ACT_LEARN_IP, 32'hC0A8_0105, 48'h0202_0000_0105, '0, ARP_OP_OTHER), 0, '0);
    add_item(mk_in(ACT_TICK, '0, '0, '0, ARP_OP_OTHER), 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) apply_setting(plan[i].setting);
      else offer_word(plan[i].word, plan[i].pinned, plan[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: s = {32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101, 32'hC0A8_01FF, 8'd6};
        1: s = {32'($urandom), 32'h0000_0000, 32'($urandom), 32'hFFFF_FFFF, 8'd255};
        2: s = {32'h0A00_0005, 32'hFFFF_FFFF, 32'h0A00_0009, 32'h0000_0000, 8'd1};
        default: begin
          s.own = $urandom;
          s.mask = 32'hFFFF_0000;
          s.gw = {s.own[31:16], 16'($urandom_range(255))};
          s.bcast = {s.own[31:16], 16'hFFFF};
          s.age = 8'($urandom_range(2, 20));
        end
      endcase
      apply_setting(s);
      addr_pool[0] = s.own;
      addr_pool[1] = s.gw;
      for (int k = 2; k < POOL - 2; k++)
        addr_pool[k] = (s.own & s.mask) | (32'($urandom) & ~s.mask);
      addr_pool[POOL - 2] = $urandom;
      addr_pool[POOL - 1] = $urandom;
      send_pct = (ph == 1) ? 82 : (ph == 3) ? 14 : 0;
      recv_pct = (ph == 2) ? 82 : (ph == 3) ? 14 : 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // long result hold-off while words keep coming, so the input backs up
        if (ph == 0 && k == 150) hold_req = 1;
        if (ph == 2 && k == 200) drain_results();
        idle_gap();
        offer_word(random_word(), 0, '0);
      end
    end

    drain_results();
    repeat (24) @(posedge clk);
    $display("tb: %0d words checked under %0d register settings, %0d entries aged out",
             n_checked, n_settings, n_expired);
    $display("tb: ticks %0d refresh %0d create %0d replace %0d hit %0d miss %0d bcast %0d ign %0d",
             status_tally[STS_TICK_DONE], status_tally[STS_REFRESHED],
             status_tally[STS_CREATED], status_tally[STS_REPLACED], status_tally[STS_HIT],
             status_tally[STS_MISS], status_tally[STS_BCAST], status_tally[STS_IGNORED]);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
